// ===== hdl/flic_byte_run_decoder_core_macros.svh =====
// Assertion macros for the FLIC byte-run decoder core.
`ifndef FLIC_BYTE_RUN_DECODER_CORE_MACROS_SVH
`define FLIC_BYTE_RUN_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define FBRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbrd assertion failed");

// Next-cycle implication, disabled during reset
`define FBRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbrd assertion failed");

`else

`define FBRD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FBRD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/fbrd_pkg.sv =====
// Types and constants shared by the FLIC byte-run decoder.
package fbrd_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ROWHDR,
      PH_COUNT,
      PH_FILLVAL,
      PH_LITERAL,
      PH_DONE
   } phase_type;

   localparam int DIM_W = 15;   // width and height register width
   localparam int POS_W = 16;   // row and column counter width

   localparam logic [2:0] CSR_ANIM_WIDTH     = 3'd0;
   localparam logic [2:0] CSR_ANIM_HEIGHT    = 3'd1;
   localparam logic [2:0] CSR_TARGET_WIDTH   = 3'd2;
   localparam logic [2:0] CSR_TARGET_HEIGHT  = 3'd3;
   localparam logic [2:0] CSR_OVERLAY_ENABLE = 3'd4;

   localparam logic [DIM_W-1:0] RST_WIDTH  = 15'd320;
   localparam logic [DIM_W-1:0] RST_HEIGHT = 15'd200;

endpackage

// ===== hdl/flic_byte_run_decoder_core.sv =====
// Top level of the FLIC byte-run decoder: state machine, run clipping and output register.
//
// Takes one BYTE_RUN payload byte per clock and turns it into at most one pixel-run write,
// presented in the cycle after the byte is accepted. The whole row/column state update and
// clipping for a byte sits between the state registers and the output register, so a
// byte can be accepted every cycle; req_tready drops only while a finished write waits
// in the output register and rsp_tready is low. Configuration writes are never stalled
// (csr_ready is tied high) and must only be made while the decoder is idle.
`include "flic_byte_run_decoder_core_macros.svh"

module flic_byte_run_decoder_core (
   input  logic        clock,
   input  logic        reset,
   // payload bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tuser,    // [0] chunk_start
   // run writes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [14:0] row, [29:15] column, [37:30] run_length,
                                     // [45:38] pixel_value, [47:46] zero
   output logic        rsp_tuser,    // [0] take_overlay
   output logic        rsp_tlast,    // frame_done
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   import fbrd_pkg::*;

   // configuration registers
   logic [DIM_W-1:0] anim_w_ff, anim_h_ff, tgt_w_ff, tgt_h_ff;
   logic             overlay_ff;

   // decoder state
   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [7:0]       left_ff, left_in;
   logic [7:0]       writ_ff, writ_in;
   logic [7:0]       fill_ff, fill_in;

   // output register
   logic             rsp_valid_ff;
   logic [DIM_W-1:0] out_row_ff, out_col_ff;
   logic [7:0]       out_len_ff, out_pix_ff;
   logic             out_ovl_ff, out_done_ff;

   logic             emit;
   logic [7:0]       emit_len;
   logic             emit_done;

   logic             accept;
   logic             start;
   logic [7:0]       din;

   // derived values
   logic [DIM_W-1:0] vis_w, vis_h;
   logic             last_row;
   logic [POS_W-1:0] row_inc;
   logic             row_over;
   logic [POS_W-1:0] fill_room, fill_col_next;
   logic [7:0]       fill_len;
   logic             fill_col_end, fill_reach;
   logic [7:0]       lit_n, lit_writ_new, lit_left_dec;
   logic [POS_W-1:0] tgt_room, lit_col_next;
   logic             lit_col_end, lit_reach;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign start      = req_tuser;
   assign din        = req_tdata;

   assign vis_w = (anim_w_ff < tgt_w_ff) ? anim_w_ff : tgt_w_ff;
   assign vis_h = (anim_h_ff < tgt_h_ff) ? anim_h_ff : tgt_h_ff;

   assign last_row = ({1'b0, row_ff} + 17'd1) >= {2'b00, vis_h};
   assign row_inc  = row_ff + 16'd1;
   assign row_over = row_inc >= {1'b0, vis_h};

   // fill run: clip to visible width
   assign fill_room     = ({1'b0, vis_w} > col_ff) ? ({1'b0, vis_w} - col_ff) : '0;
   assign fill_len      = ({8'd0, fill_ff} < fill_room) ? fill_ff : fill_room[7:0];
   assign fill_col_next = col_ff + {8'd0, fill_ff};
   assign fill_col_end  = fill_col_next >= {1'b0, vis_w};
   assign fill_reach    = ({1'b0, col_ff} + {9'd0, fill_ff}) >= {2'b00, vis_w};

   // literal run: 0x80 wraps to 128; clip against target width
   assign lit_n        = 8'(9'd256 - {1'b0, din});
   assign tgt_room     = ({1'b0, tgt_w_ff} > col_ff) ? ({1'b0, tgt_w_ff} - col_ff) : '0;
   assign lit_writ_new = ({8'd0, lit_n} < tgt_room) ? lit_n : tgt_room[7:0];
   assign lit_left_dec = (left_ff != 8'd0) ? (left_ff - 8'd1) : 8'd0;
   assign lit_col_next = col_ff + 16'd1;
   assign lit_col_end  = lit_col_next >= {1'b0, vis_w};
   assign lit_reach    = ({1'b0, col_ff} + {9'd0, left_ff}) >= {2'b00, vis_w};

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         if (vis_h == '0) begin
            phase_in = PH_DONE;
         end else if (vis_w == '0) begin
            phase_in = (vis_h <= 15'd1) ? PH_DONE : PH_ROWHDR;
         end else begin
            phase_in = PH_COUNT;
         end
      end else begin
         case (phase_ff)
            PH_ROWHDR: begin
               if (vis_w == '0) begin
                  phase_in = row_over ? PH_DONE : PH_ROWHDR;
               end else begin
                  phase_in = PH_COUNT;
               end
            end
            PH_COUNT: begin
               phase_in = din[7] ? PH_LITERAL : PH_FILLVAL;
            end
            PH_FILLVAL: begin
               if (fill_col_end) begin
                  phase_in = row_over ? PH_DONE : PH_ROWHDR;
               end else begin
                  phase_in = PH_COUNT;
               end
            end
            PH_LITERAL: begin
               if (lit_left_dec == 8'd0) begin
                  if (lit_col_end) begin
                     phase_in = row_over ? PH_DONE : PH_ROWHDR;
                  end else begin
                     phase_in = PH_COUNT;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // counters and write generation
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      writ_in   = writ_ff;
      fill_in   = fill_ff;
      emit      = 1'b0;
      emit_len  = 8'd1;
      emit_done = 1'b0;
      if (start) begin
         col_in  = '0;
         row_in  = (vis_w == '0 && vis_h != '0) ? 16'd1 : 16'd0;
         left_in = '0;
         writ_in = '0;
         fill_in = '0;
      end else begin
         case (phase_ff)
            PH_ROWHDR: begin
               col_in = '0;
               if (vis_w == '0) begin
                  row_in = row_inc;
               end
            end
            PH_COUNT: begin
               if (din[7]) begin
                  left_in = lit_n;
                  writ_in = lit_writ_new;
               end else begin
                  fill_in = din;
               end
            end
            PH_FILLVAL: begin
               emit      = fill_len != 8'd0;
               emit_len  = fill_len;
               emit_done = last_row && fill_reach;
               fill_in   = '0;
               if (fill_col_end) begin
                  col_in = '0;
                  row_in = row_inc;
               end else begin
                  col_in = fill_col_next;
               end
            end
            PH_LITERAL: begin
               emit      = writ_ff != 8'd0;
               emit_done = writ_ff == 8'd1 && last_row && lit_reach;
               writ_in   = (writ_ff != 8'd0) ? (writ_ff - 8'd1) : 8'd0;
               left_in   = lit_left_dec;
               col_in    = lit_col_next;
               if (lit_left_dec == 8'd0) begin
                  writ_in = '0;
                  if (lit_col_end) begin
                     col_in = '0;
                     row_in = row_inc;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         writ_ff  <= '0;
         fill_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
         writ_ff  <= writ_in;
         fill_ff  <= fill_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_row_ff  <= row_ff[DIM_W-1:0];
         out_col_ff  <= col_ff[DIM_W-1:0];
         out_len_ff  <= emit_len;
         out_pix_ff  <= din;
         out_ovl_ff  <= overlay_ff && (din == 8'd0);
         out_done_ff <= emit_done;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         anim_w_ff  <= RST_WIDTH;
         anim_h_ff  <= RST_HEIGHT;
         tgt_w_ff   <= RST_WIDTH;
         tgt_h_ff   <= RST_HEIGHT;
         overlay_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANIM_WIDTH:     anim_w_ff  <= csr_wdata;
            CSR_ANIM_HEIGHT:    anim_h_ff  <= csr_wdata;
            CSR_TARGET_WIDTH:   tgt_w_ff   <= csr_wdata;
            CSR_TARGET_HEIGHT:  tgt_h_ff   <= csr_wdata;
            CSR_OVERLAY_ENABLE: overlay_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_pix_ff, out_len_ff, out_col_ff, out_row_ff};
   assign rsp_tuser  = out_ovl_ff;
   assign rsp_tlast  = out_done_ff;

   // a write always covers between one and 128 pixels
   `FBRD_ASSERT_IMPL(a_run_len, clock, reset, rsp_valid_ff,
      out_len_ff != 8'd0 && out_len_ff <= 8'd128)
   // overlay flag only on zero pixels
   `FBRD_ASSERT_IMPL(a_overlay_zero, clock, reset, rsp_valid_ff && out_ovl_ff,
      out_pix_ff == 8'd0)
   // literal counters are clear outside a literal run, bounded inside one
   `FBRD_ASSERT_IMPL(a_lit_idle, clock, reset, phase_ff != PH_LITERAL,
      left_ff == 8'd0 && writ_ff == 8'd0)
   `FBRD_ASSERT_IMPL(a_lit_bound, clock, reset, phase_ff == PH_LITERAL,
      writ_ff <= left_ff && left_ff != 8'd0)

endmodule

// ===== bench/tb_flic_byte_run_decoder_core.sv =====
// Self-checking testbench for the FLIC byte-run decoder core.
`timescale 1ns / 100ps

module tb_flic_byte_run_decoder_core;
   import fbrd_pkg::*;

   localparam logic [2:0] CSR_SPARE = 3'd5;   // index beyond the register map
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned ITEM_TARGET = 500;

   typedef struct packed {
      logic [14:0] row;
      logic [14:0] column;
      logic [7:0]  run_length;
      logic [7:0]  pixel_value;
      logic        take_overlay;
      logic        frame_done;
   } run_write_type;

   // Tracks the decoder state and holds the run writes still due
   class run_scoreboard_type;
      logic [DIM_W-1:0] anim_w, anim_h, tgt_w, tgt_h;
      logic             ovl_en;
      phase_type        phase;
      logic [POS_W-1:0] col, row;
      logic [7:0]       lit_left, lit_writable, fill_len;
      run_write_type    due_writes[$];
      int unsigned      errors;

      function new();
         anim_w = RST_WIDTH;
         anim_h = RST_HEIGHT;
         tgt_w = RST_WIDTH;
         tgt_h = RST_HEIGHT;
         ovl_en = 1'b0;
         phase = PH_IDLE;
         col = '0;
         row = '0;
         lit_left = '0;
         lit_writable = '0;
         fill_len = '0;
         errors = 0;
      endfunction

      function int unsigned pending();
         return due_writes.size();
      endfunction

      function void write_reg(logic [2:0] idx, logic [14:0] v);
         case (idx)
            CSR_ANIM_WIDTH: anim_w = v;
            CSR_ANIM_HEIGHT: anim_h = v;
            CSR_TARGET_WIDTH: tgt_w = v;
            CSR_TARGET_HEIGHT: tgt_h = v;
            CSR_OVERLAY_ENABLE: ovl_en = v[0];
            default: ;
         endcase
      endfunction

      function int unsigned vis_width();
         return (anim_w < tgt_w) ? anim_w : tgt_w;
      endfunction

      function int unsigned vis_height();
         return (anim_h < tgt_h) ? anim_h : tgt_h;
      endfunction

      function bit last_row();
         int unsigned r;
         r = row;
         return r + 1 >= vis_height();
      endfunction

      function void end_row();
         row = row + 1'b1;
         col = '0;
         phase = (row >= vis_height()) ? PH_DONE : PH_ROWHDR;
      endfunction

      function void after_run();
         if (col >= vis_width()) end_row();
         else phase = PH_COUNT;
      endfunction

      function void start_row();
         col = '0;
         if (vis_width() == 0) end_row();
         else phase = PH_COUNT;
      endfunction

      function void add_write(logic [POS_W-1:0] c, int unsigned len, logic [7:0] v, bit done);
         run_write_type w;
         w.row = row[14:0];
         w.column = c[14:0];
         w.run_length = 8'(len);
         w.pixel_value = v;
         w.take_overlay = ovl_en && (v == 8'h00);
         w.frame_done = done;
         due_writes.push_back(w);
      endfunction

      function void note_byte(logic [7:0] d, logic s);
         int unsigned n, room, len, c, w;
         c = col;
         w = vis_width();
         if (s) begin
            // a chunk start restarts at row 0 (row 1 if the visible width is zero) and doubles as its packet count
            row = '0;
            col = '0;
            lit_left = '0;
            lit_writable = '0;
            fill_len = '0;
            if (vis_height() == 0) phase = PH_DONE;
            else start_row();
            return;
         end
         case (phase)
            PH_ROWHDR: start_row();
            PH_COUNT: begin
               if (d < 128) begin
                  fill_len = d;
                  phase = PH_FILLVAL;
               end else begin
                  n = 256 - d;
                  room = (tgt_w > c) ? tgt_w - c : 0;
                  lit_left = 8'(n);
                  lit_writable = 8'((n < room) ? n : room);
                  phase = PH_LITERAL;
               end
            end
            PH_FILLVAL: begin
               n = fill_len;
               room = (w > c) ? w - c : 0;
               len = (n < room) ? n : room;
               if (len > 0) add_write(col, len, d, last_row() && c + n >= w);
               col = col + fill_len;
               fill_len = '0;
               after_run();
            end
            PH_LITERAL: begin
               if (lit_writable > 0) begin
                  add_write(col, 1, d, lit_writable == 1 && last_row() && c + lit_left >= w);
                  lit_writable = lit_writable - 1'b1;
               end
               if (lit_left > 0) lit_left = lit_left - 1'b1;
               col = col + 1'b1;
               if (lit_left == 0) begin
                  lit_writable = '0;
                  after_run();
               end
            end
            default: ;
         endcase
      endfunction

      function void check_write(logic [47:0] data, logic user, logic last);
         run_write_type e, g;
         bit bad;
         g.row = data[14:0];
         g.column = data[29:15];
         g.run_length = data[37:30];
         g.pixel_value = data[45:38];
         g.take_overlay = user;
         g.frame_done = last;
         if (due_writes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected write row %0d col %0d len %0d val %02h",
                        $time, g.row, g.column, g.run_length, g.pixel_value);
            return;
         end
         e = due_writes.pop_front();
         bad = (g.row != e.row) || (g.column != e.column) || (g.run_length != e.run_length)
               || (g.pixel_value != e.pixel_value) || (g.take_overlay != e.take_overlay)
               || (g.frame_done != e.frame_done) || (data[47:46] != 2'b00);
         if (bad) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch exp row %0d col %0d len %0d val %02h ovl %0b done %0b",
                        $time, e.row, e.column, e.run_length, e.pixel_value, e.take_overlay,
                        e.frame_done,
                        " | got row %0d col %0d len %0d val %02h ovl %0b done %0b pad %0h",
                        g.row, g.column, g.run_length, g.pixel_value,
                        g.take_overlay, g.frame_done, data[47:46]);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_ANIM_WIDTH;
   logic [14:0] csr_wdata = '0;

   run_scoreboard_type board = new();
   int unsigned sent_items = 0;
   int unsigned quiet_cycles = 0;
   int unsigned sink_hold = 0;
   bit burst = 1'b0;

   flic_byte_run_decoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 60);
   endfunction

   // Result sink: short stalls mostly, the odd long one, and long ready stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_hold != 0) begin
         sink_hold--;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         sink_hold = pick_gap();
      end else begin
         rsp_tready <= 1'b1;
         sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 20);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) board.check_write(rsp_tdata, rsp_tuser, rsp_tlast);
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_wdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Hold valid high across back-to-back words; drop it only for a gap
   task automatic push_byte(input logic [7:0] d, input logic s, input bit counted);
      int unsigned gap;
      gap = burst ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (counted) sent_items++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [14:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_dims(input int unsigned aw, ah, tw, th, input bit ov, input bit spare);
      if (spare) write_csr(CSR_SPARE, 15'($urandom_range(0, 32767)));
      write_csr(CSR_ANIM_WIDTH, 15'(aw));
      write_csr(CSR_ANIM_HEIGHT, 15'(ah));
      write_csr(CSR_TARGET_WIDTH, 15'(tw));
      write_csr(CSR_TARGET_HEIGHT, 15'(th));
      write_csr(CSR_OVERLAY_ENABLE, {14'($urandom_range(0, 16383)), ov});
      csr_valid <= 1'b0;
   endtask

   // Stop sending, then wait for every due write to arrive
   task automatic drain_writes();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_noise(input int unsigned k);
      repeat (k) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0);
   endtask

   task automatic send_row(input int unsigned w);
      int unsigned c, n, left, spent, r;
      c = 0;
      spent = 0;
      while (c < w && spent < 120) begin
         left = w - c;
         r = $urandom_range(0, 9);
         if ($urandom_range(0, 1)) begin
            if (r == 0) n = 0;
            else if (r == 1) n = 127;
            else n = $urandom_range(1, (left + 2 > 127) ? 127 : left + 2);
            push_byte(8'(n), 1'b0, 1'b1);
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            spent += 2;
         end else begin
            if ($urandom_range(0, 59) == 0) n = 128;
            else if (r == 1) n = 1;
            else n = $urandom_range(1, (left + 2 > 24) ? 24 : left + 2);
            push_byte(8'(256 - n), 1'b0, 1'b1);
            repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            spent += n + 1;
         end
         c += n;
         // cut the row short now and then
         if ($urandom_range(0, 49) == 0) break;
      end
   endtask

   task automatic send_chunk(input int unsigned w, input int unsigned h);
      int unsigned rows;
      rows = (h <= 6) ? h : $urandom_range(1, 3);
      push_byte(8'($urandom_range(0, 255)), 1'b1, h != 0);
      if (h == 0) begin
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         return;
      end
      for (int unsigned r = 0; r < rows; r++) begin
         if (r != 0) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         if (w != 0) send_row(w);
         if ($urandom_range(0, 19) == 0) return;
      end
      // stray words after the last visible row
      if (rows == h && $urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
   endtask

   task automatic run_phase(input int unsigned aw, ah, tw, th, input bit ov,
                            input int unsigned chunks);
      int unsigned w, h;
      w = (aw < tw) ? aw : tw;
      h = (ah < th) ? ah : th;
      drain_writes();
      set_dims(aw, ah, tw, th, ov, $urandom_range(0, 7) == 0);
      // any open chunk carries on under the new dimensions
      send_noise($urandom_range(0, 3));
      repeat (chunks) begin
         burst = ($urandom_range(0, 3) == 0);
         send_chunk(w, h);
         if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
      end
      burst = 1'b0;
   endtask

   initial begin
      int unsigned aw, ah, tw, th;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_dims(4, 2, 4, 2, 1'b1, 1'b1);
      push_byte(8'h55, 1'b0, 1'b1);   // idle, dropped
      push_byte(8'hFF, 1'b0, 1'b1);
      push_byte(8'h00, 1'b1, 1'b1);
      push_byte(8'h00, 1'b0, 1'b1);   // zero-length fill
      push_byte(8'hAA, 1'b0, 1'b1);
      push_byte(8'h7F, 1'b0, 1'b1);   // longest fill, clipped
      push_byte(8'h00, 1'b0, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b1);   // row packet count
      push_byte(8'hFF, 1'b0, 1'b1);
      push_byte(8'h00, 1'b0, 1'b1);
      push_byte(8'hFE, 1'b0, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b1);
      push_byte(8'h80, 1'b0, 1'b1);
      push_byte(8'h01, 1'b0, 1'b1);
      push_byte(8'h5A, 1'b0, 1'b1);   // completes the frame
      push_byte(8'h33, 1'b0, 1'b1);   // past the last row, dropped
      push_byte(8'hC3, 1'b1, 1'b1);
      push_byte(8'h02, 1'b0, 1'b1);
      push_byte(8'h44, 1'b0, 1'b1);
      push_byte(8'h7E, 1'b1, 1'b1);   // restart mid-chunk
      push_byte(8'h80, 1'b0, 1'b1);
      push_byte(8'h9C, 1'b0, 1'b1);

      run_phase(12, 3, 8, 5, 1'b0, 3);          // literal words past target swallowed
      run_phase(6, 4, 20, 4, 1'b1, 3);          // literals run past the visible width
      run_phase(0, 3, 10, 3, 1'b1, 2);          // zero visible width
      run_phase(10, 32767, 10, 0, 1'b0, 2);     // zero visible height
      run_phase(32767, 2, 16, 32767, 1'b1, 2);
      run_phase(200, 1, 32767, 1, 1'b0, 1);
      run_phase(32767, 0, 32767, 6, 1'b1, 1);
      run_phase(32767, 1, 32767, 1, 1'b0, 1);

      while (sent_items < ITEM_TARGET) begin
         aw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
         tw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
         ah = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
         th = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
         run_phase(aw, ah, tw, th, 1'($urandom_range(0, 1)), $urandom_range(2, 4));
      end

      drain_writes();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         if (board.pending() != 0) $display("%0d run writes never arrived", board.pending());
         $display("FAIL");
      end
      $finish;
   end

endmodule
